// ----- rtl/tfc_pkg.sv -----
// Package: shared types, format codes and defaults for the texel converter.
package tfc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int PALETTE_WIDTH     = 24;
    localparam int APB_ADDR_WIDTH    = 3;
    localparam int APB_DATA_WIDTH    = 32;

    localparam logic [2:0] FMT_ARGB4444 = 3'd0;
    localparam logic [2:0] FMT_ARGB1555 = 3'd1;
    localparam logic [2:0] FMT_ARGB8888 = 3'd2;
    localparam logic [2:0] FMT_AI88     = 3'd3;
    localparam logic [2:0] FMT_PALETTE  = 3'd4;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_PALETTE_SIZE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] texel_word;
        logic [7:0]  entry_index;
        logic [23:0] entry_colour;
        logic        last_texel;
    } req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       image_end;
    } rsp_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [2:0] pixel_format;
        logic [8:0] palette_size;
    } cfg_t;

endpackage

// ----- rtl/tfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tfc_cfg_regs.sv -----
// APB register block: pixel format and palette size.
module tfc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [tfc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [tfc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    output tfc_pkg::cfg_t                       cfg
);

    logic [2:0] pixel_format_reg;
    logic [8:0] palette_size_reg;
    logic       wr_en;

    // Registers sit on word boundaries; only the word select bit decodes.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= tfc_pkg::FMT_ARGB4444;
            palette_size_reg <= 9'd0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == tfc_pkg::REG_PIXEL_FORMAT)
            begin
                pixel_format_reg <= pwdata[2:0];
            end
            else
            begin
                palette_size_reg <= pwdata[8:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == tfc_pkg::REG_PIXEL_FORMAT)
        begin
            prdata = {29'd0, pixel_format_reg};
        end
        else
        begin
            prdata = {23'd0, palette_size_reg};
        end
    end

    assign cfg.pixel_format = pixel_format_reg;
    assign cfg.palette_size = palette_size_reg;

endmodule

// ----- rtl/tfc_unpack.sv -----
// Format decode: widens packed texel channels to 8 bits, flags palette lookups.
module tfc_unpack (
    input  logic [2:0]      pixel_format,
    input  logic [31:0]     texel_word,
    output tfc_pkg::rgba_t  rgba,
    output logic            use_palette
);

    always_comb
    begin
        rgba        = '0;
        use_palette = 1'b0;
        case (pixel_format)
            tfc_pkg::FMT_ARGB4444:
            begin
                // Times 17 is the nibble written twice.
                rgba.red   = {texel_word[11:8],  texel_word[11:8]};
                rgba.green = {texel_word[7:4],   texel_word[7:4]};
                rgba.blue  = {texel_word[3:0],   texel_word[3:0]};
                rgba.alpha = {texel_word[15:12], texel_word[15:12]};
            end
            tfc_pkg::FMT_ARGB1555:
            begin
                rgba.red   = {texel_word[14:10], texel_word[14:12]};
                rgba.green = {texel_word[9:5],   texel_word[9:7]};
                rgba.blue  = {texel_word[4:0],   texel_word[4:2]};
                rgba.alpha = {8{texel_word[15]}};
            end
            tfc_pkg::FMT_ARGB8888:
            begin
                rgba.blue  = texel_word[7:0];
                rgba.green = texel_word[15:8];
                rgba.red   = texel_word[23:16];
                rgba.alpha = texel_word[31:24];
            end
            tfc_pkg::FMT_AI88:
            begin
                rgba.red   = texel_word[7:0];
                rgba.green = texel_word[7:0];
                rgba.blue  = texel_word[7:0];
                rgba.alpha = texel_word[15:8];
            end
            default:
            begin
                // Palette index and unused codes: color comes from the RAM.
                rgba.alpha  = 8'hFF;
                use_palette = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/texel_to_rgba8_converter.sv -----
// Top level: three-stage texel to RGBA8888 converter with palette RAM.
//
//  channel | handshake              | payload            | direction
//  --------+------------------------+--------------------+----------
//  request | req_valid / req_stall  | req_data (req_t)   | in
//  result  | rsp_valid / rsp_stall  | rsp_data (rsp_t)   | out
//  config  | psel/penable/pwrite    | paddr/pwdata       | in (APB)
//
// One request enters per clock while rsp_stall is low: each stage holds one
// request and the RAM reads and writes on separate ports. A convert request
// goes through the input register, decode and palette RAM read, and output
// register before it is offered on the result port. Palette write requests
// retire in the input stage. Reset clears valid bits and config only. req_stall
// rises only when all three stages are full and rsp_stall is high.
module texel_to_rgba8_converter #(
    parameter int PALETTE_DEPTH = tfc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  tfc_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output tfc_pkg::rsp_t                       rsp_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [tfc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [tfc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    tfc_pkg::cfg_t cfg;

    // Stage 1: input register.
    logic           s1_valid_reg;
    tfc_pkg::req_t  s1_reg;

    // Stage 2: decoded channels, palette lookup in flight.
    logic           s2_valid_reg;
    tfc_pkg::rgba_t s2_rgba_reg;
    logic           s2_use_pal_reg;
    logic           s2_in_range_reg;
    logic           s2_last_reg;

    // Stage 3: output register.
    logic           s3_valid_reg;
    tfc_pkg::rsp_t  s3_reg;

    logic           load1;
    logic           load2;
    logic           load3;
    logic           s2_valid_next;
    tfc_pkg::rgba_t dec_rgba;
    logic           dec_use_pal;
    logic           dec_in_range;
    logic           ram_we;
    logic [23:0]    ram_rdata;
    tfc_pkg::rsp_t  s3_next;

    tfc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance a stage when it is empty or its successor moves on.
    assign load3     = !s3_valid_reg || !rsp_stall;
    assign load2     = !s2_valid_reg || load3;
    assign load1     = !s1_valid_reg || load2;
    assign req_stall = !load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load1)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1 && req_valid)
        begin
            s1_reg <= req_data;
        end
    end

    // Palette writes retire here; the read for a convert request issues here.
    assign ram_we = s1_valid_reg && load2 && (s1_reg.opcode == tfc_pkg::OP_WRITE)
                    && ({1'b0, s1_reg.entry_index} < 9'(PALETTE_DEPTH));

    tfc_ram #(
        .WIDTH (tfc_pkg::PALETTE_WIDTH),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.entry_index[AW-1:0]),
        .wdata (s1_reg.entry_colour),
        .re    (load2),
        .raddr (s1_reg.texel_word[AW-1:0]),
        .rdata (ram_rdata)
    );

    tfc_unpack u_unpack (
        .pixel_format (cfg.pixel_format),
        .texel_word   (s1_reg.texel_word),
        .rgba         (dec_rgba),
        .use_palette  (dec_use_pal)
    );

    assign dec_in_range = ({1'b0, s1_reg.texel_word[7:0]} < cfg.palette_size)
                       && ({1'b0, s1_reg.texel_word[7:0]} < 9'(PALETTE_DEPTH));

    assign s2_valid_next = s1_valid_reg && (s1_reg.opcode == tfc_pkg::OP_CONVERT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (load2)
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && s2_valid_next)
        begin
            s2_rgba_reg     <= dec_rgba;
            s2_use_pal_reg  <= dec_use_pal;
            s2_in_range_reg <= dec_in_range;
            s2_last_reg     <= s1_reg.last_texel;
        end
    end

    // Merge the palette color; out-of-range indices give black.
    always_comb
    begin
        s3_next.red       = s2_rgba_reg.red;
        s3_next.green     = s2_rgba_reg.green;
        s3_next.blue      = s2_rgba_reg.blue;
        s3_next.alpha     = s2_rgba_reg.alpha;
        s3_next.image_end = s2_last_reg;
        if (s2_use_pal_reg)
        begin
            if (s2_in_range_reg)
            begin
                s3_next.red   = ram_rdata[23:16];
                s3_next.green = ram_rdata[15:8];
                s3_next.blue  = ram_rdata[7:0];
            end
            else
            begin
                s3_next.red   = 8'd0;
                s3_next.green = 8'd0;
                s3_next.blue  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (load3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign rsp_valid = s3_valid_reg;
    assign rsp_data  = s3_reg;

`ifndef SYNTHESIS
    // A palette write never turns into a result.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && load2 && (s1_reg.opcode == tfc_pkg::OP_WRITE))
        |=> !s2_valid_reg)
        else $error("palette write produced a pipeline item");

    // A held result stays valid.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("stalled result dropped");

    // Palette-mode results are always opaque.
    a_palette_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (load3 && s2_valid_reg && s2_use_pal_reg) |=> (rsp_data.alpha == 8'hFF))
        else $error("palette result not opaque");

    // Back-pressure reaches the input only when every stage is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && rsp_stall))
        else $error("input stalled with a free stage");
`endif

endmodule
